FILE: sv/daf_pkg.sv
// Shared types and constants for the decimal ASCII formatter.
package daf_pkg;

  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned DIGIT_W  = 4;

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
  localparam logic [DIGIT_W-1:0] DIGIT_BIAS = 4'd3;

  localparam logic MODE_RAW = 1'b0;
  localparam logic MODE_DEC = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SKIP = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

endpackage

FILE: sv/daf_if.sv
// Valid/ready channel interfaces for formatter input and output transactions.
interface daf_in_if;
  logic                          valid;
  logic                          ready;
  logic                          mode;
  logic [daf_pkg::NUMBER_W-1:0]  number;
  logic [daf_pkg::CHAR_W-1:0]    raw_byte;

  modport source (output valid, output mode, output number, output raw_byte, input ready);
  modport sink   (input valid, input mode, input number, input raw_byte, output ready);
endinterface

interface daf_out_if;
  logic                        valid;
  logic                        ready;
  logic [daf_pkg::CHAR_W-1:0]  out_char;
  logic                        last;

  modport source (output valid, output out_char, output last, input ready);
  modport sink   (input valid, input out_char, input last, output ready);
endinterface

FILE: sv/daf_dabble.sv
// Shift-add-3 step: corrects every BCD digit and shifts in one binary bit.
module daf_dabble #(
  parameter int unsigned NUM_DIGITS = 10
) (
  input  logic [NUM_DIGITS*daf_pkg::DIGIT_W-1:0] bcd_i,
  input  logic                                   bit_i,
  output logic [NUM_DIGITS*daf_pkg::DIGIT_W-1:0] bcd_o
);
  import daf_pkg::*;

  logic [NUM_DIGITS*DIGIT_W-1:0] adj;

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_i[i*DIGIT_W +: DIGIT_W] >= DIGIT_FIVE) begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W] + DIGIT_BIAS;
      end else begin
        adj[i*DIGIT_W +: DIGIT_W] = bcd_i[i*DIGIT_W +: DIGIT_W];
      end
    end
  end

  assign bcd_o = {adj[NUM_DIGITS*DIGIT_W-2:0], bit_i};

endmodule

FILE: sv/decimal_ascii_formatter.sv
// Top level: raw byte pass-through and binary to decimal ASCII conversion.
// Raw byte: output valid in the cycle after accept; next item follows at once unless stalled.
// Decimal: one shift-add-3 step per bit of VW (VW = min(VALUE_WIDTH, 32)), then skip leading
//   zeros and emit the digits, each emit waiting out any output stall.
// The single shift-add-3 unit sets the conversion time; in_ch.ready is low until done.
// Synchronous active-low reset returns the sequencer to idle with no output pending.
module decimal_ascii_formatter #(
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  daf_in_if.sink    in_ch,
  daf_out_if.source out_ch
);
  import daf_pkg::*;

  localparam int unsigned VW     = (VALUE_WIDTH < NUMBER_W) ? VALUE_WIDTH : NUMBER_W;
  localparam int unsigned ND     = ((VW * 1233) >> 12) + 1;
  localparam int unsigned BCD_W  = ND * DIGIT_W;
  localparam int unsigned CNT_W  = $clog2(VW + 1);
  localparam int unsigned DCNT_W = $clog2(ND + 1);

  state_t                state_r, state_nxt;
  logic [VW-1:0]         shift_r, shift_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_step;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]     out_char_r, out_char_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_free;
  logic                  in_fire;
  logic [DIGIT_W-1:0]    top_digit;

  daf_dabble #(.NUM_DIGITS(ND)) u_dabble (
    .bcd_i (bcd_r),
    .bit_i (shift_r[VW-1]),
    .bcd_o (bcd_step)
  );

  assign out_free  = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE) && out_free;
  assign in_fire   = in_ch.valid && in_ch.ready;
  assign top_digit = bcd_r[BCD_W-1 -: DIGIT_W];

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_char = out_char_r;
  assign out_ch.last     = out_last_r;

  always_comb begin
    state_nxt     = state_r;
    shift_nxt     = shift_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    dcnt_nxt      = dcnt_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_ch.mode == MODE_RAW) begin
            out_valid_nxt = 1'b1;
            out_char_nxt  = in_ch.raw_byte;
            out_last_nxt  = 1'b1;
          end else begin
            shift_nxt = in_ch.number[VW-1:0];
            bcd_nxt   = '0;
            cnt_nxt   = CNT_W'(VW);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        bcd_nxt   = bcd_step;
        shift_nxt = {shift_r[VW-2:0], 1'b0};
        cnt_nxt   = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          dcnt_nxt  = DCNT_W'(ND);
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (top_digit == '0 && dcnt_r != DCNT_W'(1)) begin
          bcd_nxt  = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dcnt_nxt = dcnt_r - DCNT_W'(1);
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + CHAR_W'(top_digit);
          out_last_nxt  = (dcnt_r == DCNT_W'(1));
          bcd_nxt       = {bcd_r[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
          dcnt_nxt      = dcnt_r - DCNT_W'(1);
          if (dcnt_r == DCNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r    <= shift_nxt;
    bcd_r      <= bcd_nxt;
    cnt_r      <= cnt_nxt;
    dcnt_r     <= dcnt_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

FILE: sv/daf_checker.sv
// Port-level checker for the decimal ASCII formatter, bound to the top level.
module daf_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        in_mode,
  input logic [daf_pkg::CHAR_W-1:0]  in_raw_byte,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [daf_pkg::CHAR_W-1:0]  out_char,
  input logic                        out_last
);
  import daf_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("output transaction changed while stalled");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> (!out_valid || out_ready))
    else $error("input ready while output slot is blocked");

  a_raw_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_RAW |=>
      out_valid && out_last && out_char == $past(in_raw_byte))
    else $error("raw byte not passed through");

  a_dec_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_DEC |=> !in_ready)
    else $error("ready during decimal conversion");

endmodule

bind decimal_ascii_formatter daf_checker u_daf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.mode),
  .in_raw_byte (in_ch.raw_byte),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_char    (out_ch.out_char),
  .out_last    (out_ch.last)
);

FILE: test/tb.sv
// Testbench for decimal_ascii_formatter: directed table plus random transactions.
`timescale 1ns / 1ps

module tb;
  import daf_pkg::*;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam int unsigned RANDOM_CHUNK = 65;

  typedef struct {
    logic [CHAR_W-1:0] out_char;
    logic              last;
  } char_beat_t;

  typedef struct {
    logic                mode;
    logic [NUMBER_W-1:0] number;
    logic [CHAR_W-1:0]   raw_byte;
    string               text;
  } stim_row_t;

  logic clk;
  logic rst_n;

  daf_in_if  in_ch();
  daf_out_if out_ch();

  decimal_ascii_formatter #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  char_beat_t  pending_chars[$];
  char_beat_t  head_char;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  bit          burst = 0;
  bit          hold_long = 0;

  stim_row_t directed_rows[] = '{
    '{MODE_DEC, 32'd0,          8'h00, "0"},
    '{MODE_DEC, 32'd0,          8'hFF, "0"},
    '{MODE_DEC, 32'd1,          8'h00, "1"},
    '{MODE_DEC, 32'd9,          8'h39, "9"},
    '{MODE_DEC, 32'd10,         8'h00, "10"},
    '{MODE_DEC, 32'd99,         8'h00, "99"},
    '{MODE_DEC, 32'd100,        8'h00, "100"},
    '{MODE_DEC, 32'd4096,       8'h00, "4096"},
    '{MODE_DEC, 32'hFFFFFFFF,   8'hFF, "4294967295"},
    '{MODE_DEC, 32'd1000000000, 8'h00, "1000000000"},
    '{MODE_DEC, 32'd999999999,  8'h00, "999999999"},
    '{MODE_DEC, 32'h80000000,   8'h00, "2147483648"},
    '{MODE_DEC, 32'hAAAAAAAA,   8'h55, ""},
    '{MODE_DEC, 32'h55555555,   8'hAA, ""},
    '{MODE_RAW, 32'hFFFFFFFF,   8'h00, ""},
    '{MODE_RAW, 32'h00000000,   8'hFF, ""},
    '{MODE_RAW, 32'd0,          8'h25, "%"},
    '{MODE_RAW, 32'd12345,      8'h41, "A"},
    '{MODE_RAW, 32'hAAAAAAAA,   8'h80, ""},
    '{MODE_RAW, 32'h55555555,   8'h7F, ""}
  };

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic void queue_formatted_chars(input logic mode, input logic [NUMBER_W-1:0] number,
                                                input logic [CHAR_W-1:0] raw_byte);
    logic [NUMBER_W-1:0] value_mask;
    logic [NUMBER_W-1:0] value;
    logic [DIGIT_W-1:0]  digits[10];
    int                  count;
    char_beat_t          beat;
    value_mask = (VALUE_WIDTH >= NUMBER_W) ? '1 : ((32'h1 << VALUE_WIDTH) - 1);
    value = number & value_mask;
    count = 0;
    if (mode == MODE_RAW) begin
      beat.out_char = raw_byte;
      beat.last = 1'b1;
      pending_chars.push_back(beat);
    end else begin
      do begin
        digits[count] = DIGIT_W'(value % 10);
        value = value / 10;
        count++;
      end while (value != 0);
      for (int k = count - 1; k >= 0; k--) begin
        beat.out_char = ASCII_ZERO + CHAR_W'(digits[k]);
        beat.last = (k == 0);
        pending_chars.push_back(beat);
      end
    end
  endfunction

  function automatic void queue_typed_chars(input string text);
    char_beat_t beat;
    for (int i = 0; i < text.len(); i++) begin
      beat.out_char = text[i];
      beat.last = (i == text.len() - 1);
      pending_chars.push_back(beat);
    end
  endfunction

  // Drive one transaction at the falling edge and hold it until accepted.
  task automatic send_item(input logic mode, input logic [NUMBER_W-1:0] number,
                           input logic [CHAR_W-1:0] raw_byte, input string text);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.mode = mode;
    in_ch.number = number;
    in_ch.raw_byte = raw_byte;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    if (text.len() > 0) queue_typed_chars(text);
    else queue_formatted_chars(mode, number, raw_byte);
    @(negedge clk);
  endtask

  task automatic send_random_items(input int unsigned n);
    logic                mode;
    logic [NUMBER_W-1:0] number;
    int unsigned         sel;
    int unsigned         span;
    for (int i = 0; i < n; i++) begin
      mode = ($urandom_range(0, 2) != 0) ? MODE_DEC : MODE_RAW;
      sel = $urandom_range(0, 9);
      if (sel == 0) begin
        number = '0;
      end else if (sel <= 3) begin
        number = $urandom;
      end else begin
        span = 10 ** $urandom_range(1, 9);
        number = $urandom_range(0, span - 1);
      end
      send_item(mode, number, CHAR_W'($urandom_range(0, 255)), "");
    end
  endtask

  task automatic wait_drained();
    while (pending_chars.size() != 0) @(posedge clk);
  endtask

  // Receiver: random stalls per character, plus one long hold-off on request.
  initial begin
    int unsigned stall;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        out_ch.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_long = 0;
      end
      stall = burst ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ch.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected char 0x%02h last %0b", $time, out_ch.out_char, out_ch.last);
        error_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_ch.out_char !== head_char.out_char) begin
          $display("%0t: out_char expected 0x%02h actual 0x%02h",
                   $time, head_char.out_char, out_ch.out_char);
          error_count++;
        end
        if (out_ch.last !== head_char.last) begin
          $display("%0t: last expected %0b actual %0b", $time, head_char.last, out_ch.last);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_RAW;
    in_ch.number = '0;
    in_ch.raw_byte = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].mode, directed_rows[i].number,
                directed_rows[i].raw_byte, directed_rows[i].text);

    send_random_items(RANDOM_CHUNK);

    hold_long = 1;
    send_random_items(RANDOM_CHUNK);

    in_ch.valid = 1'b0;
    wait_drained();
    @(negedge clk);

    burst = 1;
    send_random_items(RANDOM_CHUNK);
    burst = 0;

    send_random_items(RANDOM_CHUNK);
    in_ch.valid = 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_chars.size() != 0) begin
      $display("%0t: %0d chars never arrived", $time, pending_chars.size());
      error_count++;
    end

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: decimal_ascii_formatter.f
sv/daf_pkg.sv
sv/daf_if.sv
sv/daf_dabble.sv
sv/decimal_ascii_formatter.sv
sv/daf_checker.sv
test/tb.sv
